// ===== rtl/ctbc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctbc_pkg
// Shared types, constants and syndrome helpers for the (26,16) two-bit
// corrector: generator 0x5B9, single-bit syndrome table, status codes.
// ----------------------------------------------------------------------------
package ctbc_pkg;

    localparam int WORD_W  = 26;
    localparam int CHECK_W = 10;
    localparam int DATA_W  = WORD_W - CHECK_W;
    localparam int IDX_W   = $clog2(WORD_W);

    localparam logic [CHECK_W:0] GEN_POLY = 11'h5B9;

    localparam logic [1:0] ST_CLEAN = 2'd0;
    localparam logic [1:0] ST_ONE   = 2'd1;
    localparam logic [1:0] ST_TWO   = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [CHECK_W-1:0] t_syn;
    typedef logic [DATA_W-1:0]  t_data;
    typedef logic [1:0]         t_status;
    typedef logic [WORD_W-1:0][CHECK_W-1:0] t_syn_tab;

    // one beat from the front to the back
    typedef struct packed {
        t_syn  syn;
        t_data data;
    } t_qbeat;

    // entry k is x^k mod g, the syndrome of an error at codeword bit k
    function automatic t_syn_tab build_syn_tab();
        t_syn_tab         tab;
        logic [CHECK_W:0] r;
        r = {{CHECK_W{1'b0}}, 1'b1};
        for (int k = 0; k < WORD_W; k++) begin
            tab[k] = r[CHECK_W-1:0];
            r = {r[CHECK_W-1:0], 1'b0};
            if (r[CHECK_W]) begin
                r = r ^ GEN_POLY;
            end
        end
        return tab;
    endfunction

    localparam t_syn_tab SYN_TAB = build_syn_tab();

    function automatic t_syn syndrome(t_word w);
        t_syn s;
        s = '0;
        for (int k = 0; k < WORD_W; k++) begin
            if (w[k]) begin
                s = s ^ SYN_TAB[k];
            end
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ctbc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctbc_front
// Front end: takes command beats and computes the 10-bit syndrome of each
// codeword, handing syndrome and raw data to the queue.
// ----------------------------------------------------------------------------
module ctbc_front (
    input  wire logic              i_start,
    input  wire logic              i_full,
    input  wire ctbc_pkg::t_word   i_codeword,
    output logic                   o_push,
    output logic                   o_busy,
    output ctbc_pkg::t_qbeat       o_beat
);

    assign o_busy = i_full;
    assign o_push = i_start && !i_full;
    assign o_beat = {ctbc_pkg::syndrome(i_codeword),
                     i_codeword[ctbc_pkg::WORD_W-1:ctbc_pkg::CHECK_W]};

endmodule
`default_nettype wire

// ===== rtl/ctbc_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctbc_queue
// Short FIFO between the front end and the correction back end.
// ----------------------------------------------------------------------------
module ctbc_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire ctbc_pkg::t_qbeat  i_beat,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output logic                   o_full,
    output ctbc_pkg::t_qbeat       o_beat
);

    ctbc_pkg::t_qbeat                r_mem [ctbc_pkg::QUEUE_DEPTH];
    logic [ctbc_pkg::QPTR_W-1:0]     r_wr;
    logic [ctbc_pkg::QPTR_W-1:0]     r_rd;
    logic [ctbc_pkg::QCNT_W-1:0]     r_count;
    logic [ctbc_pkg::QPTR_W-1:0]     n_wr;
    logic [ctbc_pkg::QPTR_W-1:0]     n_rd;
    logic [ctbc_pkg::QCNT_W-1:0]     n_count;
    logic                            pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == ctbc_pkg::QCNT_W'(ctbc_pkg::QUEUE_DEPTH));
    assign o_beat  = r_mem[r_rd];
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == ctbc_pkg::QPTR_W'(ctbc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == ctbc_pkg::QPTR_W'(ctbc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_beat;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ctbc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ctbc_back
// Back end: matches the syndrome against single and pair error patterns,
// then picks the first match in priority order and flips the data bits.
// ----------------------------------------------------------------------------
module ctbc_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire ctbc_pkg::t_qbeat  i_beat,
    output logic                   o_pop,
    output logic                   o_valid,
    output ctbc_pkg::t_data        o_data_word,
    output ctbc_pkg::t_status      o_fix_status
);

    // match stage
    logic                                               r_s1_valid;
    logic                                               r_zero;
    logic [ctbc_pkg::WORD_W-1:0]                        r_single;
    logic [ctbc_pkg::WORD_W-1:0]                        r_row_hit;
    logic [ctbc_pkg::WORD_W-1:0][ctbc_pkg::IDX_W-1:0]   r_row_q;
    ctbc_pkg::t_data                                    r_s1_data;
    logic [ctbc_pkg::WORD_W-1:0]                        n_single;
    logic [ctbc_pkg::WORD_W-1:0]                        n_row_hit;
    logic [ctbc_pkg::WORD_W-1:0][ctbc_pkg::IDX_W-1:0]   n_row_q;

    // select stage
    logic                          r_valid;
    ctbc_pkg::t_data               r_data_word;
    ctbc_pkg::t_status             r_fix_status;
    ctbc_pkg::t_data               n_data_word;
    ctbc_pkg::t_status             n_fix_status;
    logic                          hit1;
    logic                          hit2;
    logic [ctbc_pkg::IDX_W-1:0]    p1;
    logic [ctbc_pkg::IDX_W-1:0]    p2;
    logic [ctbc_pkg::IDX_W-1:0]    q2;
    ctbc_pkg::t_word               mask;

    assign o_pop = i_valid;

    // higher q within a row and higher rows win: codeword bit 25 comes first
    always_comb begin
        n_single  = '0;
        n_row_hit = '0;
        n_row_q   = '0;
        for (int p = 0; p < ctbc_pkg::WORD_W; p++) begin
            n_single[p] = (i_beat.syn == ctbc_pkg::SYN_TAB[p]);
            for (int q = 0; q < ctbc_pkg::WORD_W; q++) begin
                if (q < p) begin
                    if (i_beat.syn == (ctbc_pkg::SYN_TAB[p] ^ ctbc_pkg::SYN_TAB[q])) begin
                        n_row_hit[p] = 1'b1;
                        n_row_q[p]   = ctbc_pkg::IDX_W'(q);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero    <= (i_beat.syn == '0);
        r_single  <= n_single;
        r_row_hit <= n_row_hit;
        r_row_q   <= n_row_q;
        r_s1_data <= i_beat.data;
    end

    always_comb begin
        hit1 = 1'b0;
        hit2 = 1'b0;
        p1   = '0;
        p2   = '0;
        q2   = '0;
        for (int p = 0; p < ctbc_pkg::WORD_W; p++) begin
            if (r_single[p]) begin
                hit1 = 1'b1;
                p1   = ctbc_pkg::IDX_W'(p);
            end
            if (r_row_hit[p]) begin
                hit2 = 1'b1;
                p2   = ctbc_pkg::IDX_W'(p);
                q2   = r_row_q[p];
            end
        end

        priority if (r_zero) begin
            mask         = '0;
            n_fix_status = ctbc_pkg::ST_CLEAN;
        end else if (hit1) begin
            mask         = ctbc_pkg::t_word'(1) << p1;
            n_fix_status = ctbc_pkg::ST_ONE;
        end else if (hit2) begin
            mask         = (ctbc_pkg::t_word'(1) << p2) | (ctbc_pkg::t_word'(1) << q2);
            n_fix_status = ctbc_pkg::ST_TWO;
        end else begin
            mask         = '0;
            n_fix_status = ctbc_pkg::ST_BAD;
        end
        n_data_word = r_s1_data ^ mask[ctbc_pkg::WORD_W-1:ctbc_pkg::CHECK_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data_word  <= n_data_word;
        r_fix_status <= n_fix_status;
    end

    assign o_valid      = r_valid;
    assign o_data_word  = r_data_word;
    assign o_fix_status = r_fix_status;

endmodule
`default_nettype wire

// ===== rtl/cyclic_26_16_two_bit_corrector.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cyclic_26_16_two_bit_corrector
// Decoder for the shortened (26,16) cyclic code, generator 0x5B9, that
// corrects any one or two bit errors and reports what it did.
//
// Input: a codeword is taken at a rising edge with start high and busy low;
// data in bits 25..10, check bits in bits 9..0.
// Output: o_valid is high for one cycle with o_data_word and o_fix_status
// (0 clean, 1 one bit fixed, 2 two bits fixed, 3 uncorrectable, raw data).
// The receiver has no way to stall, and none is needed.
// Throughput: one codeword per cycle, sustained; busy stays low in use,
// since the back end drains the two-entry queue every cycle.
// Path: the accepted codeword passes the queue write, the match register
// and the output register, in that order, before the result is on the ports.
// Reset: synchronous, active low; clears the queue and both valid flags,
// nothing in flight survives it.
// ----------------------------------------------------------------------------
module cyclic_26_16_two_bit_corrector (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire ctbc_pkg::t_word         i_codeword,
    output logic                         o_valid,
    output ctbc_pkg::t_data              o_data_word,
    output ctbc_pkg::t_status            o_fix_status
);

    logic             push;
    logic             full;
    logic             q_valid;
    logic             pop;
    ctbc_pkg::t_qbeat front_beat;
    ctbc_pkg::t_qbeat q_beat;

    ctbc_front u_front (
        .i_start    (start),
        .i_full     (full),
        .i_codeword (i_codeword),
        .o_push     (push),
        .o_busy     (busy),
        .o_beat     (front_beat)
    );

    ctbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_beat  (front_beat),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (full),
        .o_beat  (q_beat)
    );

    ctbc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_beat       (q_beat),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_data_word  (o_data_word),
        .o_fix_status (o_fix_status)
    );

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the (26,16) two-bit corrector. A short table of
// directed codewords (clean words, single and double flips, check-bit-only
// flips, raw patterns) is followed by random encoded words carrying zero,
// one or two flips, mixed with raw noise. Each accepted word is scored by
// its typed table entry, else by a local syndrome decoder. Each result beat
// is compared with the oldest pending prediction. Sender gaps come in random bursts.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RANDOM_BEATS   = 450;
    localparam int CALM_TAIL      = 100;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int VECTOR_COUNT   = 20;

    typedef struct packed {
        ctbc_pkg::t_data   data;
        ctbc_pkg::t_status status;
    } t_fix;

    typedef struct {
        ctbc_pkg::t_data   data;
        ctbc_pkg::t_word   flips;
        bit                typed;
        ctbc_pkg::t_data   exp_data;
        ctbc_pkg::t_status exp_status;
    } t_vector;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              start      = 1'b0;
    ctbc_pkg::t_word   i_codeword = '0;
    logic              busy;
    logic              o_valid;
    ctbc_pkg::t_data   o_data_word;
    ctbc_pkg::t_status o_fix_status;

    ctbc_pkg::t_syn bit_syn [ctbc_pkg::WORD_W];
    t_fix           pending_fixes [$];
    int             error_count  = 0;
    int             quiet_cycles = 0;

    always #10 i_clk = ~i_clk;

    cyclic_26_16_two_bit_corrector u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_codeword   (i_codeword),
        .o_valid      (o_valid),
        .o_data_word  (o_data_word),
        .o_fix_status (o_fix_status)
    );

    // long division by the generator, msb first
    function automatic ctbc_pkg::t_syn remainder_of(ctbc_pkg::t_word w);
        ctbc_pkg::t_word v;
        v = w;
        for (int k = ctbc_pkg::WORD_W - 1; k >= ctbc_pkg::CHECK_W; k--) begin
            if (v[k]) begin
                v[k -: ctbc_pkg::CHECK_W + 1] = v[k -: ctbc_pkg::CHECK_W + 1]
                                                ^ ctbc_pkg::GEN_POLY;
            end
        end
        return v[ctbc_pkg::CHECK_W-1:0];
    endfunction

    function automatic ctbc_pkg::t_word encode(ctbc_pkg::t_data d);
        return {d, remainder_of({d, {ctbc_pkg::CHECK_W{1'b0}}})};
    endfunction

    // bit_syn[i] holds the syndrome of a flip at codeword bit 25 - i
    function automatic t_fix predict_fix(ctbc_pkg::t_word w);
        ctbc_pkg::t_syn    syn;
        ctbc_pkg::t_word   fixed;
        ctbc_pkg::t_status st;
        bit                found;
        syn   = remainder_of(w);
        fixed = w;
        st    = ctbc_pkg::ST_BAD;
        found = (syn == '0);
        if (found) begin
            st = ctbc_pkg::ST_CLEAN;
        end
        for (int i = 0; i < ctbc_pkg::WORD_W && !found; i++) begin
            if (syn == bit_syn[i]) begin
                fixed = w ^ (ctbc_pkg::t_word'(1) << (ctbc_pkg::WORD_W - 1 - i));
                st    = ctbc_pkg::ST_ONE;
                found = 1'b1;
            end
        end
        for (int i = 0; i < ctbc_pkg::WORD_W && !found; i++) begin
            for (int j = i + 1; j < ctbc_pkg::WORD_W && !found; j++) begin
                if (syn == (bit_syn[i] ^ bit_syn[j])) begin
                    fixed = w ^ (ctbc_pkg::t_word'(1) << (ctbc_pkg::WORD_W - 1 - i))
                              ^ (ctbc_pkg::t_word'(1) << (ctbc_pkg::WORD_W - 1 - j));
                    st    = ctbc_pkg::ST_TWO;
                    found = 1'b1;
                end
            end
        end
        return '{data: fixed[ctbc_pkg::WORD_W-1:ctbc_pkg::CHECK_W], status: st};
    endfunction

    task automatic drive_beat(ctbc_pkg::t_word w, bit typed, t_fix known);
        start      <= 1'b1;
        i_codeword <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_fixes.insert(pending_fixes.size(), typed ? known : predict_fix(w));
    endtask

    task automatic idle_burst(int n);
        start <= 1'b0;
        repeat (n) begin
            i_codeword <= ctbc_pkg::t_word'($urandom);
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_fixes.size() != 0) @(posedge i_clk);
    endtask

    // result beats
    always @(posedge i_clk) begin
        t_fix want;
        if (i_rst_n && o_valid) begin
            if (pending_fixes.size() == 0) begin
                $error("unexpected beat: data_word %h fix_status %0d",
                       o_data_word, o_fix_status);
                error_count++;
            end else begin
                want = pending_fixes.pop_front();
                if (o_data_word !== want.data) begin
                    $error("data_word: expected %h actual %h", want.data, o_data_word);
                    error_count++;
                end
                if (o_fix_status !== want.status) begin
                    $error("fix_status: expected %0d actual %0d",
                           want.status, o_fix_status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_vector         vectors [VECTOR_COUNT];
        ctbc_pkg::t_word w;
        int              kind;
        int              a;
        int              b;

        for (int i = 0; i < ctbc_pkg::WORD_W; i++) begin
            bit_syn[i] = remainder_of(ctbc_pkg::t_word'(1) << (ctbc_pkg::WORD_W - 1 - i));
        end

        // data, flips, typed, expected data, expected status
        vectors = '{
            '{16'h0000, 26'h0000000, 1'b1, 16'h0000, ctbc_pkg::ST_CLEAN},
            '{16'hFFFF, 26'h0000000, 1'b1, 16'hFFFF, ctbc_pkg::ST_CLEAN},
            '{16'hA5C3, 26'h0000000, 1'b1, 16'hA5C3, ctbc_pkg::ST_CLEAN},
            '{16'h0000, 26'h2000000, 1'b1, 16'h0000, ctbc_pkg::ST_ONE},
            '{16'hFFFF, 26'h0000400, 1'b1, 16'hFFFF, ctbc_pkg::ST_ONE},
            '{16'hFFFF, 26'h2000000, 1'b1, 16'hFFFF, ctbc_pkg::ST_ONE},
            // flips in check bits only leave the data alone
            '{16'h1234, 26'h0000200, 1'b1, 16'h1234, ctbc_pkg::ST_ONE},
            '{16'h1234, 26'h0000001, 1'b1, 16'h1234, ctbc_pkg::ST_ONE},
            '{16'h8001, 26'h0000003, 1'b0, 16'h0000, ctbc_pkg::ST_CLEAN},
            '{16'h5A5A, 26'h3000000, 1'b0, 16'h0000, ctbc_pkg::ST_CLEAN},
            '{16'h5A5A, 26'h2000001, 1'b0, 16'h0000, ctbc_pkg::ST_CLEAN},
            '{16'hC3C3, 26'h0002080, 1'b0, 16'h0000, ctbc_pkg::ST_CLEAN},
            '{16'h0F0F, 26'h0000C00, 1'b0, 16'h0000, ctbc_pkg::ST_CLEAN},
            '{16'hFFFF, 26'h0000007, 1'b0, 16'h0000, ctbc_pkg::ST_CLEAN},
            '{16'h8001, 26'h2000424, 1'b0, 16'h0000, ctbc_pkg::ST_CLEAN},
            // raw patterns, mostly uncorrectable
            '{16'h0000, 26'h3FFFFFF, 1'b0, 16'h0000, ctbc_pkg::ST_CLEAN},
            '{16'h0000, 26'h2AAAAAA, 1'b0, 16'h0000, ctbc_pkg::ST_CLEAN},
            '{16'h0000, 26'h1555555, 1'b0, 16'h0000, ctbc_pkg::ST_CLEAN},
            '{16'h0000, 26'h00003FF, 1'b0, 16'h0000, ctbc_pkg::ST_CLEAN},
            '{16'h0000, 26'h3FFFC00, 1'b0, 16'h0000, ctbc_pkg::ST_CLEAN}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (vectors[k]) begin
            if ($urandom_range(0, 3) == 0) begin
                idle_burst($urandom_range(1, 16));
            end
            drive_beat(encode(vectors[k].data) ^ vectors[k].flips, vectors[k].typed,
                       '{data: vectors[k].exp_data, status: vectors[k].exp_status});
        end
        wait_drained();

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n < RANDOM_BEATS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
                idle_burst($urandom_range(1, 16));
            end
            if (n == RANDOM_BEATS / 2) begin
                wait_drained();
            end
            kind = $urandom_range(0, 9);
            w    = encode(ctbc_pkg::t_data'($urandom));
            a    = $urandom_range(0, ctbc_pkg::WORD_W - 1);
            b    = $urandom_range(0, ctbc_pkg::WORD_W - 2);
            if (b >= a) begin
                b++;
            end
            case (kind)
                0, 1, 2: begin
                end
                3, 4, 5: begin
                    w = w ^ (ctbc_pkg::t_word'(1) << a);
                end
                6, 7: begin
                    w = w ^ (ctbc_pkg::t_word'(1) << a) ^ (ctbc_pkg::t_word'(1) << b);
                end
                default: begin
                    w = ctbc_pkg::t_word'($urandom);
                end
            endcase
            drive_beat(w, 1'b0, '0);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ctbc_pkg.sv
rtl/ctbc_front.sv
rtl/ctbc_queue.sv
rtl/ctbc_back.sv
rtl/cyclic_26_16_two_bit_corrector.sv
test/testbench.sv
